// ===== hdl/assert_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CRB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define CRB_ASSERT(lbl, clk, rst_n, prop)
`define CRB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/crb_pkg.sv =====
package crb_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int ACC_W       = 63;
    localparam int MAG_W       = 62;
    localparam int CHUNK_A     = 31;
    localparam logic [MAG_W-1:0] ACC_SAT = '1;

    localparam logic REG_SCAN_LOW  = 1'b0;
    localparam logic REG_SCAN_HIGH = 1'b1;

    typedef struct packed {
        logic signed [31:0] coef_cubic;
        logic signed [31:0] coef_square;
        logic signed [31:0] coef_linear;
        logic signed [31:0] coef_const;
    } t_item;

    typedef struct packed {
        logic signed [31:0] root_value;
        logic               root_valid;
        logic               last_root;
    } t_result;

    typedef enum logic [1:0] {SG_ZERO, SG_POS, SG_NEG} t_sgn;
    typedef enum logic [1:0] {SEL_L, SEL_R, SEL_M} t_sel;
    typedef enum logic [1:0] {DEC_ROOT, DEC_NONE, DEC_LEFT, DEC_RIGHT} t_dec;
    typedef enum logic [1:0] {H_IDLE, H_PREP, H_MUL, H_ADD} t_hstate;
    typedef enum logic [3:0] {
        ST_IDLE, ST_INTV, ST_GO_L, ST_WT_L, ST_GO_R, ST_WT_R,
        ST_GO_M, ST_WT_M, ST_STEP, ST_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic intv;
        logic eval_go;
        t_sel sel;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic eval_done;
        logic dec_cont;
    } t_dp_sts;

    function automatic logic opposite(t_sgn a, t_sgn b);
        return (a == SG_POS && b == SG_NEG) || (a == SG_NEG && b == SG_POS);
    endfunction

endpackage

// ===== hdl/crb_horner.sv =====
module crb_horner #(
    parameter int F = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [F+8:0]   i_x,
    input  crb_pkg::t_item        i_coef,
    output logic                  o_done,
    output crb_pkg::t_sgn         o_sign
);
    import crb_pkg::*;

    localparam int XW  = F + 9;
    localparam int MXW = XW - 1;
    localparam int MH  = (MXW + 1) / 2;
    localparam int PW  = MAG_W + 2 * MH;
    localparam logic signed [63:0] SAT_P = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_N = -SAT_P;

    t_hstate r_st, n_st;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [MAG_W-1:0] r_ma, n_ma;
    logic [2*MH-1:0] r_mx, n_mx;
    logic r_neg, n_neg;
    logic [PW-1:0] r_prod, n_prod;
    logic [1:0] r_phase, n_phase;
    logic [1:0] r_term, n_term;
    logic r_done, n_done;

    logic [ACC_W-1:0] w_a_abs;
    logic [XW-1:0] w_x_abs;
    logic [CHUNK_A-1:0] w_a_ch;
    logic [MH-1:0] w_x_ch;
    logic [CHUNK_A+MH-1:0] w_pp;
    logic [7:0] w_sh;
    logic [PW-1:0] w_pp_sh;
    logic [PW-1:0] w_shr;
    logic [MAG_W-1:0] w_mag;
    logic signed [63:0] w_prod;
    logic signed [31:0] w_coef;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_clamp;

    assign w_a_abs = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
    assign w_x_abs = i_x[XW-1] ? XW'(-i_x) : XW'(i_x);
    assign w_a_ch  = r_phase[0] ? r_ma[2*CHUNK_A-1:CHUNK_A] : r_ma[CHUNK_A-1:0];
    assign w_x_ch  = r_phase[1] ? r_mx[2*MH-1:MH] : r_mx[MH-1:0];
    assign w_pp    = w_a_ch * w_x_ch;
    assign w_sh    = 8'((r_phase[0] ? CHUNK_A : 0) + (r_phase[1] ? MH : 0));
    assign w_pp_sh = PW'(w_pp) << w_sh;
    assign w_shr   = r_prod >> F;
    assign w_mag   = (w_shr > PW'(ACC_SAT)) ? ACC_SAT : w_shr[MAG_W-1:0];
    assign w_prod  = r_neg ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag});

    always_comb begin
        case (r_term)
            2'd1:    w_coef = i_coef.coef_square;
            2'd2:    w_coef = i_coef.coef_linear;
            default: w_coef = i_coef.coef_const;
        endcase
    end

    assign w_sum = w_prod + 64'(w_coef);

    always_comb begin
        if (w_sum > SAT_P) begin
            w_clamp = SAT_P;
        end else if (w_sum < SAT_N) begin
            w_clamp = SAT_N;
        end else begin
            w_clamp = w_sum;
        end
    end

    always_comb begin
        n_st    = r_st;
        n_acc   = r_acc;
        n_ma    = r_ma;
        n_mx    = r_mx;
        n_neg   = r_neg;
        n_prod  = r_prod;
        n_phase = r_phase;
        n_term  = r_term;
        n_done  = 1'b0;
        case (r_st)
            H_IDLE: begin
                if (i_start) begin
                    n_acc  = ACC_W'(i_coef.coef_cubic);
                    n_term = 2'd1;
                    n_st   = H_PREP;
                end
            end
            H_PREP: begin
                n_ma    = w_a_abs[MAG_W-1:0];
                n_mx    = (2*MH)'(w_x_abs[XW-2:0]);
                n_neg   = r_acc[ACC_W-1] ^ i_x[XW-1];
                n_prod  = '0;
                n_phase = '0;
                n_st    = H_MUL;
            end
            H_MUL: begin
                n_prod  = r_prod + w_pp_sh;
                n_phase = r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    n_st = H_ADD;
                end
            end
            H_ADD: begin
                n_acc = ACC_W'(w_clamp);
                if (r_term == 2'd3) begin
                    n_done = 1'b1;
                    n_st   = H_IDLE;
                end else begin
                    n_term = r_term + 2'd1;
                    n_st   = H_PREP;
                end
            end
            default: n_st = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= H_IDLE;
            r_done <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_done <= n_done;
        end
        r_acc   <= n_acc;
        r_ma    <= n_ma;
        r_mx    <= n_mx;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_phase <= n_phase;
        r_term  <= n_term;
    end

    assign o_done = r_done;
    assign o_sign = (r_acc == '0) ? SG_ZERO : (r_acc[ACC_W-1] ? SG_NEG : SG_POS);

endmodule

// ===== hdl/crb_dp.sv =====
module crb_dp #(
    parameter int F = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  crb_pkg::t_dp_cmd      i_cmd,
    output crb_pkg::t_dp_sts      o_sts,
    input  crb_pkg::t_item        i_item,
    input  logic signed [7:0]     i_scan_low,
    input  logic signed [7:0]     i_scan_high,
    output logic                  o_strobe,
    output crb_pkg::t_result      o_result
);
    import crb_pkg::*;

    localparam int XW = F + 9;

    t_item r_coef;
    logic signed [XW-1:0] r_left, r_right, r_pend;
    logic signed [8:0] r_idx;
    t_sgn r_sl, r_sr, r_sm;
    t_sel r_sel;
    logic [4:0] r_iter;
    logic r_pend_vld;
    logic [1:0] r_cnt;
    logic r_strobe;
    t_result r_result;

    logic signed [XW:0] w_diff;
    logic signed [XW-1:0] w_mid, w_x, w_root;
    logic signed [9:0] w_idx1;
    t_dec w_dec;
    logic w_hdone;
    t_sgn w_hsign;
    logic w_dup;

    function automatic logic signed [31:0] sat32(logic signed [XW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (e < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return e[31:0];
    endfunction

    assign w_diff = (XW+1)'(r_right) - (XW+1)'(r_left);
    assign w_mid  = r_left + XW'(w_diff >>> 1);
    assign w_idx1 = 10'(r_idx) + 10'sd1;

    always_comb begin
        case (r_sel)
            SEL_L:   w_x = r_left;
            SEL_R:   w_x = r_right;
            default: w_x = w_mid;
        endcase
    end

    always_comb begin
        w_root = r_left;
        if (r_sm == SG_ZERO) begin
            w_dec  = DEC_ROOT;
            w_root = w_mid;
        end else if (r_sl == SG_ZERO) begin
            w_dec = DEC_ROOT;
        end else if (r_sr == SG_ZERO) begin
            w_dec  = DEC_ROOT;
            w_root = r_right;
        end else if (w_diff <= (XW+1)'(1)) begin
            w_dec = (r_iter != '0 || opposite(r_sl, r_sr)) ? DEC_ROOT : DEC_NONE;
        end else if (opposite(r_sm, r_sl)) begin
            w_dec = DEC_RIGHT;
        end else if (opposite(r_sm, r_sr)) begin
            w_dec = DEC_LEFT;
        end else begin
            w_dec = DEC_NONE;
        end
    end

    assign w_dup = r_pend_vld && (w_root == r_pend);

    crb_horner #(.F(F)) u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.eval_go),
        .i_x     (w_x),
        .i_coef  (r_coef),
        .o_done  (w_hdone),
        .o_sign  (w_hsign)
    );

    assign o_sts.scan_done = (r_idx > 9'(i_scan_high)) || (r_cnt == 2'(MAX_RESULTS));
    assign o_sts.eval_done = w_hdone;
    assign o_sts.dec_cont  = (w_dec == DEC_LEFT) || (w_dec == DEC_RIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_strobe <= i_cmd.finish
                        || (i_cmd.step && (w_dec == DEC_ROOT) && !w_dup && r_pend_vld);
            if (i_cmd.load) begin
                r_coef     <= i_item;
                r_idx      <= 9'(i_scan_low);
                r_pend_vld <= 1'b0;
                r_cnt      <= '0;
            end
            if (i_cmd.intv) begin
                r_left  <= XW'(r_idx) <<< F;
                r_right <= XW'(w_idx1) <<< F;
                r_iter  <= '0;
            end
            if (i_cmd.eval_go) begin
                r_sel <= i_cmd.sel;
            end
            if (w_hdone) begin
                case (r_sel)
                    SEL_L:   r_sl <= w_hsign;
                    SEL_R:   r_sr <= w_hsign;
                    default: r_sm <= w_hsign;
                endcase
            end
            if (i_cmd.step) begin
                case (w_dec)
                    DEC_ROOT: begin
                        r_idx <= 9'(w_idx1);
                        if (!w_dup) begin
                            if (r_pend_vld) begin
                                r_result.root_value <= sat32(r_pend);
                                r_result.root_valid <= 1'b1;
                                r_result.last_root  <= 1'b0;
                            end
                            r_pend     <= w_root;
                            r_pend_vld <= 1'b1;
                            r_cnt      <= r_cnt + 2'd1;
                        end
                    end
                    DEC_LEFT: begin
                        r_left <= w_mid;
                        r_sl   <= r_sm;
                        r_iter <= r_iter + 5'd1;
                    end
                    DEC_RIGHT: begin
                        r_right <= w_mid;
                        r_sr    <= r_sm;
                        r_iter  <= r_iter + 5'd1;
                    end
                    default: r_idx <= 9'(w_idx1);
                endcase
            end
            if (i_cmd.finish) begin
                r_result.root_value <= r_pend_vld ? sat32(r_pend) : '0;
                r_result.root_valid <= r_pend_vld;
                r_result.last_root  <= 1'b1;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hdl/crb_ctrl.sv =====
module crb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  crb_pkg::t_dp_sts  i_sts,
    output crb_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import crb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_INTV;
                end
            end
            ST_INTV: begin
                if (i_sts.scan_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.intv = 1'b1;
                    n_state    = ST_GO_L;
                end
            end
            ST_GO_L: begin
                o_cmd.eval_go = 1'b1;
                o_cmd.sel     = SEL_L;
                n_state       = ST_WT_L;
            end
            ST_WT_L: if (i_sts.eval_done) n_state = ST_GO_R;
            ST_GO_R: begin
                o_cmd.eval_go = 1'b1;
                o_cmd.sel     = SEL_R;
                n_state       = ST_WT_R;
            end
            ST_WT_R: if (i_sts.eval_done) n_state = ST_GO_M;
            ST_GO_M: begin
                o_cmd.eval_go = 1'b1;
                o_cmd.sel     = SEL_M;
                n_state       = ST_WT_M;
            end
            ST_WT_M: if (i_sts.eval_done) n_state = ST_STEP;
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.dec_cont ? ST_GO_M : ST_INTV;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== hdl/cubic_root_bisection_top.sv =====
// channel   | signals                                      | transaction
// ----------+----------------------------------------------+---------------------------------
// item in   | start, busy, i_item                          | start high while busy low
// result    | o_result_strobe, o_result                    | strobe high for one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata | psel, penable, pwrite, pready high
//
// a sign evaluation is a go, then per term a prep, 4 partial multiplies and a sum
// a unit interval evaluates the left, right and middle signs and takes a step; each further
// bisection re-evaluates the middle and steps again, down to an interval one step wide
// each item closes its scan in the intv and fin states; the last transaction comes as busy drops
// a root is held until the next one is found or the scan ends; the receiver cannot stall
// synchronous active-low reset
`include "assert_macros.svh"

module cubic_root_bisection_top #(
    parameter int ROOT_FRAC_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  crb_pkg::t_item    i_item,
    output logic              o_result_strobe,
    output crb_pkg::t_result  o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import crb_pkg::*;

    logic signed [7:0] r_scan_low, r_scan_high;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_low  <= -8'sd100;
            r_scan_high <= 8'sd100;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_SCAN_LOW) begin
                r_scan_low <= pwdata[7:0];
            end else begin
                r_scan_high <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_SCAN_HIGH) ? 32'(r_scan_high) : 32'(r_scan_low);

    crb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    crb_dp #(.F(ROOT_FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (i_item),
        .i_scan_low  (r_scan_low),
        .i_scan_high (r_scan_high),
        .o_strobe    (o_result_strobe),
        .o_result    (o_result)
    );

    `CRB_ASSERT(a_last_ends_item, i_clk, i_rst_n, (o_result_strobe && o_result.last_root) |-> !busy)
    `CRB_ASSERT(a_mid_in_item, i_clk, i_rst_n, (o_result_strobe && !o_result.last_root) |-> busy)
    `CRB_ASSERT(a_invalid_is_last, i_clk, i_rst_n, (o_result_strobe && !o_result.root_valid) |-> o_result.last_root)
    `CRB_ASSERT(a_start_takes, i_clk, i_rst_n, (start && !busy) |=> busy)

endmodule

// ===== tb/sv/cubic_root_bisection_top_tb.sv =====
`timescale 1ns / 1ps

module cubic_root_bisection_top_tb;
    import crb_pkg::*;

    localparam int WATCHDOG_CYCLES = 600000;
    localparam longint SAT62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint ONE_X = 64'sd1 <<< 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_result_strobe;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cubic_root_bisection_top dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_result     expected_roots[$];
    logic signed [7:0] scan_lo = -8'sd100;
    logic signed [7:0] scan_hi = 8'sd100;
    longint      coefs[4];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          watchdog = 0;
    bit          no_idle = 1'b0;

    function automatic longint mul_shift(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 24;
        return (p > SAT62) ? SAT62 : longint'(p[63:0]);
    endfunction

    function automatic int eval_sign(longint x);
        longint acc, prod, m;
        acc = coefs[0];
        for (int k = 1; k < 4; k++) begin
            m = mul_shift(acc < 0 ? -acc : acc, x < 0 ? -x : x);
            prod = ((acc < 0) != (x < 0)) ? -m : m;
            acc = prod + coefs[k];
            if (acc > SAT62) acc = SAT62;
            if (acc < -SAT62) acc = -SAT62;
        end
        return acc > 0 ? 1 : (acc < 0 ? -1 : 0);
    endfunction

    function automatic bit bisect_interval(longint l, longint r, output longint root);
        longint m;
        int sm, sl, sr, steps;
        steps = 0;
        forever begin
            m = l + ((r - l) >>> 1);
            sm = eval_sign(m);
            sl = eval_sign(l);
            sr = eval_sign(r);
            if (sm == 0) begin root = m; return 1; end
            if (sl == 0) begin root = l; return 1; end
            if (sr == 0) begin root = r; return 1; end
            if (r - l <= 1) begin
                root = l;
                return (steps != 0) || (sl * sr < 0);
            end
            if (sm * sl < 0) r = m;
            else if (sm * sr < 0) l = m;
            else return 0;
            steps++;
        end
    endfunction

    function automatic void add_expected(t_result res);
        expected_roots = {expected_roots, res};
    endfunction

    task automatic predict_roots(t_item it);
        longint root, prev, v;
        bit seen;
        int n;
        t_result res;
        coefs[0] = it.coef_cubic;
        coefs[1] = it.coef_square;
        coefs[2] = it.coef_linear;
        coefs[3] = it.coef_const;
        seen = 0;
        prev = 0;
        n = 0;
        for (int i = scan_lo; i <= scan_hi && n < MAX_RESULTS; i++) begin
            if (!bisect_interval(i * ONE_X, (i + 1) * ONE_X, root)) continue;
            if (seen && root == prev) continue;
            v = root;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res.root_value = v[31:0];
            res.root_valid = 1'b1;
            res.last_root = 1'b0;
            add_expected(res);
            prev = root;
            seen = 1;
            n++;
        end
        if (n == 0) begin
            res = '0;
            res.last_root = 1'b1;
            add_expected(res);
        end else begin
            expected_roots[expected_roots.size() - 1].last_root = 1'b1;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            results_seen++;
            if (expected_roots.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_result);
                errors++;
            end else begin
                t_result e;
                e = expected_roots.pop_front();
                if (e.root_value !== o_result.root_value) begin
                    $display("%0t: root_value expected %h actual %h", $time,
                             e.root_value, o_result.root_value);
                    errors++;
                end
                if (e.root_valid !== o_result.root_valid) begin
                    $display("%0t: root_valid expected %b actual %b", $time,
                             e.root_valid, o_result.root_valid);
                    errors++;
                end
                if (e.last_root !== o_result.last_root) begin
                    $display("%0t: last_root expected %b actual %b", $time,
                             e.last_root, o_result.last_root);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_strobe) watchdog <= 0;
        else watchdog <= watchdog + 1;
        if (watchdog >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_item(t_item it);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 34) begin
            start = 1'b0;
            i_item = {$urandom, $urandom, $urandom, $urandom};
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item = it;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        predict_roots(it);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_roots.size() != 0 || busy) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic signed [7:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = {{24{val[7]}}, val};
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {~idx, 2'b00};
        @(negedge i_clk);
        psel = 1'b1;
        paddr = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata[7:0] !== val) begin
            $display("%0t: register %0d readback expected %h actual %h", $time,
                     idx, val, prdata[7:0]);
            errors++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (idx == REG_SCAN_LOW) scan_lo = val;
        else scan_hi = val;
    endtask

    task automatic set_scan(logic signed [7:0] lo, logic signed [7:0] hi);
        wait_idle();
        write_reg(REG_SCAN_LOW, lo);
        write_reg(REG_SCAN_HIGH, hi);
    endtask

    // k (x - q1/4)(x - q2/4)(x - q3/4) in Q16.16
    function automatic t_item cubic_from_roots(int k, int q1, int q2, int q3);
        t_item it;
        it.coef_cubic  = k <<< 16;
        it.coef_square = -k * (q1 + q2 + q3) <<< 14;
        it.coef_linear = k * (q1 * q2 + q1 * q3 + q2 * q3) <<< 12;
        it.coef_const  = -k * q1 * q2 * q3 <<< 10;
        return it;
    endfunction

    task automatic test_default_range();
        send_item(cubic_from_roots(1, 4, 8, 12));
        send_item(cubic_from_roots(-2, 1, 6, -3));
    endtask

    task automatic test_extremes();
        t_item it;
        set_scan(-8'sd128, 8'sd127);
        send_item('0);
        it = '0;
        it.coef_const = 32'sd1 <<< 16;
        send_item(it);
        set_scan(8'sd127, 8'sd127);
        it = '0;
        it.coef_linear = 32'sd1 <<< 16;
        it.coef_const = -(32'sd128 <<< 16);
        send_item(it);
        set_scan(-8'sd128, -8'sd127);
        it.coef_const = 32'sd128 <<< 16;
        send_item(it);
        set_scan(-8'sd2, 8'sd1);
        send_item('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
        send_item('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        send_item('{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
        send_item(cubic_from_roots(1, -4, 0, 4));
        send_item(cubic_from_roots(3, -6, -6, 2));
    endtask

    task automatic test_special_cases();
        set_scan(8'sd5, 8'sd4);
        send_item(cubic_from_roots(1, 20, 21, 22));
        set_scan(8'sd0, 8'sd0);
        send_item(cubic_from_roots(0, 0, 0, 0));
        send_item('{32'sd0, 32'sd1 <<< 16, -(32'sd1 <<< 15), 32'sd5 <<< 8});
        send_item('{32'sd0, 32'sd1 <<< 16, -(32'sd1 <<< 15), 32'sd1 <<< 10});
        send_item(cubic_from_roots(1, 1, 2, 3));
    endtask

    task automatic test_random_items();
        int lo, width, q[3];
        t_item it;
        for (int g = 0; g < 12; g++) begin
            lo = $urandom_range(20) - 12;
            width = $urandom_range(4);
            if ($urandom_range(19) == 0) set_scan(8'(lo), 8'(lo - 1));
            else set_scan(8'(lo), 8'(lo + width));
            no_idle = (g == 5);
            for (int n = 0; n < 8; n++) begin
                for (int j = 0; j < 3; j++)
                    q[j] = 4 * lo - 2 + $urandom_range(4 * width + 8);
                it = cubic_from_roots(int'($urandom_range(8)) - 4, q[0], q[1], q[2]);
                case ($urandom_range(9))
                    0, 1: it = {$urandom, $urandom, $urandom, $urandom};
                    2: it.coef_const = it.coef_const + int'($urandom_range(2047)) - 1024;
                    default: ;
                endcase
                send_item(it);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_range();
        test_extremes();
        test_special_cases();
        test_random_items();
        wait_idle();
        $display("sent %0d items and checked %0d results over scan ranges up to full width",
                 items_sent, results_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
